@@ design/serial_bank_switch_mapper_unit_macros.svh @@
// Assertion macros for the serial bank switch mapper
`ifndef SERIAL_BANK_SWITCH_MAPPER_UNIT_MACROS_SVH
`define SERIAL_BANK_SWITCH_MAPPER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define SBSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define SBSM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define SBSM_ASSERT(lbl, prop, msg)
`define SBSM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ design/sbsm_pkg.sv @@
// Package: types, constants and helpers for the serial bank switch mapper
`timescale 1ns / 1ps
`default_nettype none

package sbsm_pkg;

    localparam int MAP_W   = 18;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int COUNT_W = 5;

    // access kinds
    localparam logic [1:0] MODE_CPU_RD = 2'd0;
    localparam logic [1:0] MODE_CPU_WR = 2'd1;
    localparam logic [1:0] MODE_PPU    = 2'd2;

    // register selected by address bits 14:13 on commit
    localparam logic [1:0] REG_CONTROL = 2'd0;
    localparam logic [1:0] REG_CHR0    = 2'd1;
    localparam logic [1:0] REG_CHR1    = 2'd2;
    localparam logic [1:0] REG_PRG     = 2'd3;

    // PRG banking modes, control bits 3:2
    localparam logic [1:0] PRG_MODE_32K_A  = 2'd0;
    localparam logic [1:0] PRG_MODE_32K_B  = 2'd1;
    localparam logic [1:0] PRG_MODE_FIX_LO = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_HI = 2'd3;

    localparam logic [15:0] RAM_WIN_LO = 16'h6000;
    localparam logic [15:0] RAM_WIN_HI = 16'h7FFF;

    localparam logic [4:0] CTRL_RESET      = 5'h0C;
    localparam logic [4:0] PRG_COUNT_RESET = 5'd16;
    localparam logic [2:0] SHIFT_LAST      = 3'd4;

    typedef struct packed {
        logic [MAP_W-1:0] mapped_address;
        logic [1:0]       mirroring_mode;
        logic             ram_enable;
    } t_result;

    function automatic logic [3:0] last_bank(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] dec;
        dec = count - 5'd1;
        return dec[3:0];
    endfunction

endpackage

`default_nettype wire

@@ design/sbsm_core.sv @@
// Mapper state registers, serial loader and address translation
`timescale 1ns / 1ps
`default_nettype none
`include "serial_bank_switch_mapper_unit_macros.svh"

module sbsm_core
    import sbsm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire logic [1:0]         i_mode,
    input  wire logic [ADDR_W-1:0]  i_address,
    input  wire logic [DATA_W-1:0]  i_value,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [COUNT_W-1:0] i_cfg_wr_data,
    output t_result                 o_result
);

    logic [COUNT_W-1:0] r_prg_count, n_prg_count;
    logic [4:0]         r_shift_value, n_shift_value;
    logic [2:0]         r_shift_count, n_shift_count;
    logic [4:0]         r_control, n_control;
    logic [4:0]         r_chr_low, n_chr_low;
    logic [4:0]         r_chr_high, n_chr_high;
    logic [3:0]         r_prg_low, n_prg_low;
    logic [3:0]         r_prg_high, n_prg_high;
    logic               r_ram_on, n_ram_on;

    logic               in_ram_win;
    logic [4:0]         shifted;
    logic [MAP_W-1:0]   mapped;

    assign in_ram_win = (i_address >= RAM_WIN_LO) && (i_address <= RAM_WIN_HI);
    assign shifted    = {i_value[0], r_shift_value[4:1]};

    always_comb begin
        n_prg_count   = r_prg_count;
        n_shift_value = r_shift_value;
        n_shift_count = r_shift_count;
        n_control     = r_control;
        n_chr_low     = r_chr_low;
        n_chr_high    = r_chr_high;
        n_prg_low     = r_prg_low;
        n_prg_high    = r_prg_high;
        n_ram_on      = r_ram_on;
        if (i_cfg_wr_en) begin
            n_prg_count = i_cfg_wr_data;
            n_prg_high  = last_bank(i_cfg_wr_data);
        end else if (i_accept && i_mode == MODE_CPU_WR && !in_ram_win) begin
            if (i_value[7]) begin
                n_control     = r_control | CTRL_RESET;
                n_shift_value = '0;
                n_shift_count = '0;
            end else if (r_shift_count >= SHIFT_LAST) begin
                n_shift_value = '0;
                n_shift_count = '0;
                if (i_address[15]) begin
                    case (i_address[14:13])
                        REG_CONTROL: begin
                            n_control = shifted;
                        end
                        REG_CHR0: begin
                            n_chr_low = r_control[4] ? shifted : {1'b0, shifted[4:1]};
                        end
                        REG_CHR1: begin
                            n_chr_high = shifted;
                        end
                        default: begin
                            case (r_control[3:2]) inside
                                PRG_MODE_32K_A, PRG_MODE_32K_B: begin
                                    n_prg_low = {1'b0, shifted[3:1]};
                                end
                                PRG_MODE_FIX_LO: begin
                                    n_prg_low  = '0;
                                    n_prg_high = shifted[3:0];
                                end
                                default: begin
                                    n_prg_low  = shifted[3:0];
                                    n_prg_high = last_bank(r_prg_count);
                                end
                            endcase
                            n_ram_on = !shifted[4];
                        end
                    endcase
                end
            end else begin
                n_shift_value = shifted;
                n_shift_count = r_shift_count + 3'd1;
            end
        end
    end

    // reads and PPU fetches leave state alone, so current banks serve them
    always_comb begin
        case (i_mode)
            MODE_CPU_RD: begin
                if (in_ram_win) begin
                    mapped = {5'd0, i_address[12:0]};
                end else if (r_control[3]) begin
                    if (i_address[15:14] == 2'b10) begin
                        mapped = {r_prg_low, i_address[13:0]};
                    end else begin
                        mapped = {r_prg_high, i_address[13:0]};
                    end
                end else begin
                    mapped = {r_prg_low[2:0], i_address[14:0]};
                end
            end
            MODE_CPU_WR: begin
                mapped = in_ram_win ? {5'd0, i_address[12:0]} : {2'd0, i_address};
            end
            default: begin
                if (r_control[4]) begin
                    if (i_address[15:12] == 4'd0) begin
                        mapped = {1'b0, r_chr_low, i_address[11:0]};
                    end else begin
                        mapped = {1'b0, r_chr_high, i_address[11:0]};
                    end
                end else begin
                    mapped = {r_chr_low, i_address[12:0]};
                end
            end
        endcase
    end

    assign o_result = {mapped, n_control[1:0], n_ram_on};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_count   <= PRG_COUNT_RESET;
            r_shift_value <= '0;
            r_shift_count <= '0;
            r_control     <= CTRL_RESET;
            r_chr_low     <= '0;
            r_chr_high    <= '0;
            r_prg_low     <= '0;
            r_prg_high    <= last_bank(PRG_COUNT_RESET);
            r_ram_on      <= 1'b1;
        end else begin
            r_prg_count   <= n_prg_count;
            r_shift_value <= n_shift_value;
            r_shift_count <= n_shift_count;
            r_control     <= n_control;
            r_chr_low     <= n_chr_low;
            r_chr_high    <= n_chr_high;
            r_prg_low     <= n_prg_low;
            r_prg_high    <= n_prg_high;
            r_ram_on      <= n_ram_on;
        end
    end

    `SBSM_ASSERT(a_shift_count_range, r_shift_count <= SHIFT_LAST, "shift count beyond fifth bit")
    `SBSM_ASSERT(a_reset_bit_sets_prg_mode,
        (i_accept && !i_cfg_wr_en && i_mode == MODE_CPU_WR && !in_ram_win && i_value[7])
        |=> (r_control[3:2] == PRG_MODE_FIX_HI && r_shift_count == 3'd0),
        "reset bit write did not force PRG mode")
    `SBSM_ASSERT(a_cfg_sets_top_bank, i_cfg_wr_en |=> (r_prg_high == last_bank(r_prg_count)),
        "bank count write did not reload top bank")

endmodule

`default_nettype wire

@@ design/serial_bank_switch_mapper_unit.sv @@
// An accepted word is registered in the output or, on a stall, the skid register.
// One word per cycle while skid is empty; all translation is one combinational stage.
// An output register plus a skid register decouple the two sides, so input
// stays ready while a single result waits downstream.
// Reset (i_rst_n low, synchronous): output empty, mapper state to power-on
// values (control 0x0C, PRG bank count 16, PRG RAM enabled).
`timescale 1ns / 1ps
`default_nettype none
`include "serial_bank_switch_mapper_unit_macros.svh"

module serial_bank_switch_mapper_unit
    import sbsm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [23:0]        i_s_axis_tdata,  // address[15:0], value[23:16]
    input  wire logic [1:0]         i_s_axis_tuser,  // mode[1:0]
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [23:0]             o_m_axis_tdata,  // mapped_address[17:0],
                                                     // mirroring_mode[19:18],
                                                     // ram_enable[20], zero[23:21]
    input  wire logic               i_cfg_wr_en,
    input  wire logic [COUNT_W-1:0] i_cfg_wr_data
);

    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result result;
    logic    accept;
    logic    out_free;

    assign o_s_axis_tready = !r_skid_valid;
    assign accept          = i_s_axis_tvalid && !r_skid_valid;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    sbsm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_mode        (i_s_axis_tuser),
        .i_address     (i_s_axis_tdata[15:0]),
        .i_value       (i_s_axis_tdata[23:16]),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (result)
    );

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = accept;
                n_skid       = result;
            end else begin
                n_out       = result;
                n_out_valid = accept;
            end
        end else if (accept) begin
            n_skid       = result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'd0, r_out.ram_enable, r_out.mirroring_mode,
                              r_out.mapped_address};

    `SBSM_ASSERT(a_skid_implies_out, r_skid_valid |-> r_out_valid, "skid word without output word")
    `SBSM_ASSERT(a_accept_lands,
        (accept && !r_out_valid) |=> (r_out_valid && !r_skid_valid),
        "accepted word lost on empty output")
    `SBSM_ASSERT(a_stall_fills_skid,
        (accept && r_out_valid && !i_m_axis_tready) |=> r_skid_valid,
        "stalled word not held in skid register")
    `SBSM_ASSERT_ALWAYS(a_reset_empties,
        !i_rst_n |=> (!r_out_valid && !r_skid_valid),
        "output not empty after reset")

endmodule

`default_nettype wire
